>>> sv/thread_queue_search_remove_assert.svh
// assertion macros shared by the thread queue rtl
// no dependencies; included by the controller and the datapath
`ifndef THREAD_QUEUE_SEARCH_REMOVE_ASSERT_SVH
`define THREAD_QUEUE_SEARCH_REMOVE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TQSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TQSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tqsr_pkg.sv
// types and constants for the thread queue with search and removal
// no dependencies; used by every module of the block
`default_nettype none

package tqsr_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int HANDLE_W    = 8;
	localparam int ID_W        = 16;
	localparam int OCC_W       = 5;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_PUT    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_TAKE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [HANDLE_W-1:0] handle;
		logic [ID_W-1:0]     thread_id;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle_out;
		logic [ID_W-1:0]     id_out;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

	// steps the controller hands to the datapath
	typedef struct packed {
		logic load;
		logic match;
		logic pick;
		logic commit;
	} ctl_t;

endpackage

`default_nettype wire

>>> sv/tqsr_dp.sv
// datapath: entry store, match vector, oldest-match pick and compaction
// depends on tqsr_pkg and thread_queue_search_remove_assert.svh
`default_nettype none

`include "thread_queue_search_remove_assert.svh"

module tqsr_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tqsr_pkg::ctl_t ctl,
	input  wire tqsr_pkg::req_t req,
	output tqsr_pkg::rsp_t     rsp
);

	localparam int D = tqsr_pkg::QUEUE_DEPTH;

	logic [tqsr_pkg::HANDLE_W-1:0] hnd_q [D];
	logic [tqsr_pkg::ID_W-1:0]     id_q  [D];
	logic [tqsr_pkg::CNT_W-1:0]    count_q;
	tqsr_pkg::req_t                req_q;
	logic [D-1:0]                  match_q;
	logic [D-1:0]                  first_q;
	logic [D-1:0]                  shift_q;
	logic [tqsr_pkg::HANDLE_W-1:0] sel_hnd_q;
	logic [tqsr_pkg::ID_W-1:0]     sel_id_q;
	tqsr_pkg::rsp_t                rsp_q;

	logic [D-1:0]                  match_d;
	logic [D-1:0]                  first_d;
	logic [D-1:0]                  below_d;
	logic [tqsr_pkg::HANDLE_W-1:0] sel_hnd_d;
	logic [tqsr_pkg::ID_W-1:0]     sel_id_d;
	logic                          full;
	logic                          hit;
	logic                          do_put;
	logic                          do_drop;
	logic [tqsr_pkg::CNT_W-1:0]    count_d;
	tqsr_pkg::rsp_t                rsp_d;

	// per-entry compare against the request, only below the fill count
	always_comb begin
		for (int i = 0; i < D; i++) begin
			match_d[i] = 1'b0;
			if (tqsr_pkg::CNT_W'(i) < count_q) begin
				case (req_q.cmd)
					tqsr_pkg::CMD_LOOKUP: match_d[i] = (id_q[i] == req_q.thread_id);
					tqsr_pkg::CMD_REMOVE: match_d[i] = (hnd_q[i] == req_q.handle);
					tqsr_pkg::CMD_TAKE:   match_d[i] = (i == 0);
					default:              match_d[i] = 1'b0;
				endcase
			end
		end
	end

	// lowest set bit is the oldest match; everything at or above it shifts down
	always_comb begin
		first_d   = match_q & (~match_q + D'(1));
		below_d   = first_d - D'(1);
		sel_hnd_d = '0;
		sel_id_d  = '0;
		for (int i = 0; i < D; i++) begin
			sel_hnd_d = sel_hnd_d | (first_d[i] ? hnd_q[i] : '0);
			sel_id_d  = sel_id_d  | (first_d[i] ? id_q[i]  : '0);
		end
	end

	assign full    = (count_q == tqsr_pkg::CNT_W'(D));
	assign hit     = |first_q;
	assign do_put  = ctl.commit && (req_q.cmd == tqsr_pkg::CMD_PUT) && !full;
	assign do_drop = ctl.commit && hit &&
		((req_q.cmd == tqsr_pkg::CMD_REMOVE) || (req_q.cmd == tqsr_pkg::CMD_TAKE));

	always_comb begin
		count_d = count_q;
		rsp_d   = '{status: tqsr_pkg::ST_MISS, handle_out: '0, id_out: '0, occupancy: '0};
		case (req_q.cmd)
			tqsr_pkg::CMD_PUT: begin
				if (full) begin
					rsp_d.status = tqsr_pkg::ST_FULL;
				end else begin
					count_d          = count_q + tqsr_pkg::CNT_W'(1);
					rsp_d.status     = tqsr_pkg::ST_OK;
					rsp_d.handle_out = req_q.handle;
					rsp_d.id_out     = req_q.thread_id;
				end
			end
			tqsr_pkg::CMD_LOOKUP: begin
				if (hit) begin
					rsp_d.status     = tqsr_pkg::ST_OK;
					rsp_d.handle_out = sel_hnd_q;
					rsp_d.id_out     = sel_id_q;
				end
			end
			default: begin
				if (hit) begin
					count_d          = count_q - tqsr_pkg::CNT_W'(1);
					rsp_d.status     = tqsr_pkg::ST_OK;
					rsp_d.handle_out = sel_hnd_q;
					rsp_d.id_out     = sel_id_q;
				end
			end
		endcase
		rsp_d.occupancy = tqsr_pkg::OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.commit) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.match) begin
			match_q <= match_d;
		end
		if (ctl.pick) begin
			first_q   <= first_d;
			shift_q   <= ~below_d;
			sel_hnd_q <= sel_hnd_d;
			sel_id_q  <= sel_id_d;
		end
		if (ctl.commit) begin
			rsp_q <= rsp_d;
		end
	end

	// entry store: append at the tail, or close the gap left by a drop
	for (genvar g = 0; g < D; g++) begin : g_entry
		if (g < D - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (do_put && (count_q[tqsr_pkg::IDX_W-1:0] == tqsr_pkg::IDX_W'(g))) begin
					hnd_q[g] <= req_q.handle;
					id_q[g]  <= req_q.thread_id;
				end else if (do_drop && shift_q[g]) begin
					hnd_q[g] <= hnd_q[g+1];
					id_q[g]  <= id_q[g+1];
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (do_put && (count_q[tqsr_pkg::IDX_W-1:0] == tqsr_pkg::IDX_W'(g))) begin
					hnd_q[g] <= req_q.handle;
					id_q[g]  <= req_q.thread_id;
				end
			end
		end
	end

	assign rsp = rsp_q;

	`TQSR_ASSERT_NOW(a_count_bounded, clk, arst_n, 1'b1, count_q <= tqsr_pkg::CNT_W'(D), "entry count above queue depth")
	`TQSR_ASSERT_NEXT(a_pick_onehot, clk, arst_n, ctl.pick, $onehot0(first_q) && ((first_q & ~match_q) == '0), "picked entry is not a single matching entry")

endmodule

`default_nettype wire

>>> sv/tqsr_ctrl.sv
// controller: sequences load, match, pick and commit for one command
// depends on tqsr_pkg and thread_queue_search_remove_assert.svh
`default_nettype none

`include "thread_queue_search_remove_assert.svh"

module tqsr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output tqsr_pkg::ctl_t     ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_PICK,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MATCH;
						busy_q  <= 1'b1;
					end
				end
				S_MATCH: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign ctl.load   = start && !busy_q;
	assign ctl.match  = (state_q == S_MATCH);
	assign ctl.pick   = (state_q == S_PICK);
	assign ctl.commit = (state_q == S_COMMIT);
	assign busy       = busy_q;
	assign done       = done_q;

	`TQSR_ASSERT_NEXT(a_accept_starts, clk, arst_n, start && !busy_q, busy_q && (state_q == S_MATCH), "accepted beat did not start the sequence")
	`TQSR_ASSERT_NOW(a_done_after_commit, clk, arst_n, done_q, !busy_q && ($past(state_q) == S_COMMIT), "result strobe without a commit")

endmodule

`default_nettype wire

>>> sv/thread_queue_search_remove.sv
// top level of the thread queue with search and removal
// depends on tqsr_pkg, tqsr_ctrl and tqsr_dp
`default_nettype none

// ordered queue of up to 16 thread entries (handle plus thread id), oldest first
//
// request side: a beat is taken at a rising edge with start high and busy low;
//   req carries cmd (put, lookup by id, remove by handle, take head), handle
//   and thread_id
// result side: exactly one result beat per request, shown on rsp for one
//   cycle while done is high; the receiver cannot stall, so nothing waits
// sequence: the accepting edge starts the match, pick and commit steps of
//   the controller; done rises as commit ends and the result beat is taken
//   at the edge that ends the done cycle; busy stays high from the accepting
//   edge and drops with done, so a new request may be taken at the edge that
//   ends the cycle showing the previous result
// requests do not overlap: a new one is not taken while busy is high
// match compares every entry at once, pick finds the oldest match and its
//   data, commit writes the store: append at the tail, or shift the entries
//   above a removed one down by one
// reset: the queue comes up empty and idle; entry contents are not cleared,
//   only entries below the fill count are ever read

module thread_queue_search_remove (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire tqsr_pkg::req_t req,
	output logic                done,
	output tqsr_pkg::rsp_t      rsp
);

	// step strobes from the controller to the datapath
	tqsr_pkg::ctl_t ctl;

	tqsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// store, compare vector and registered result live here
	tqsr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_thread_queue_search_remove.sv
// testbench for thread_queue_search_remove: directed and random command traffic
// checked against an in-bench model of the ordered queue
// depends on tqsr_pkg and thread_queue_search_remove
`default_nettype none

module tb_thread_queue_search_remove;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	tqsr_pkg::req_t req = '0;
	logic busy;
	logic done;
	tqsr_pkg::rsp_t rsp;

	thread_queue_search_remove uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model of the queue contents, head at index 0
	logic [tqsr_pkg::HANDLE_W-1:0] model_handles[$];
	logic [tqsr_pkg::ID_W-1:0]     model_ids[$];

	// results owed by the block, oldest first
	tqsr_pkg::rsp_t pending_results[$];

	int error_count = 0;
	int no_gap_run = 0;

	// applies one command to the queue model and returns the result it must produce
	function automatic tqsr_pkg::rsp_t apply_queue_op(input tqsr_pkg::req_t r);
		tqsr_pkg::rsp_t res;
		int hit;
		res = '{status: tqsr_pkg::ST_MISS, handle_out: '0, id_out: '0, occupancy: '0};
		hit = -1;
		case (r.cmd)
			tqsr_pkg::CMD_PUT: begin
				if (model_handles.size() >= tqsr_pkg::QUEUE_DEPTH) begin
					res.status = tqsr_pkg::ST_FULL;
				end else begin
					model_handles.push_back(r.handle);
					model_ids.push_back(r.thread_id);
					res.status = tqsr_pkg::ST_OK;
					res.handle_out = r.handle;
					res.id_out = r.thread_id;
				end
			end
			tqsr_pkg::CMD_LOOKUP: begin
				// oldest entry with this id wins
				foreach (model_ids[i])
					if (hit < 0 && model_ids[i] == r.thread_id)
						hit = i;
			end
			tqsr_pkg::CMD_REMOVE: begin
				foreach (model_handles[i])
					if (hit < 0 && model_handles[i] == r.handle)
						hit = i;
			end
			default: begin
				if (model_handles.size() > 0)
					hit = 0;
			end
		endcase
		if (hit >= 0) begin
			res.status = tqsr_pkg::ST_OK;
			res.handle_out = model_handles[hit];
			res.id_out = model_ids[hit];
			// remove and take close the gap, the rest keep their order
			if (r.cmd != tqsr_pkg::CMD_LOOKUP) begin
				model_handles.delete(hit);
				model_ids.delete(hit);
			end
		end
		res.occupancy = tqsr_pkg::OCC_W'(model_handles.size());
		return res;
	endfunction

	// idle length after a beat: mostly none or short, a few long, with
	// occasional runs of back-to-back beats
	function automatic int pick_gap();
		int r;
		if (no_gap_run > 0) begin
			no_gap_run--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 5)
			no_gap_run = $urandom_range(10, 40);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// drives one request beat, waits for the accepting edge, records the
	// owed result, then idles at random; start stays high when no gap follows
	task automatic send_cmd(input tqsr_pkg::cmd_t c,
			input logic [tqsr_pkg::HANDLE_W-1:0] h,
			input logic [tqsr_pkg::ID_W-1:0] id);
		tqsr_pkg::req_t beat;
		int gap;
		beat = '{cmd: c, handle: h, thread_id: id};
		start <= 1'b1;
		req <= beat;
		// accepted at the first edge where busy reads low
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(apply_queue_op(beat));
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// holds off the request side until every owed result has come back
	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// result checker: done marks a one-cycle result beat, sampled at the
	// edge that ends it
	always @(posedge clk) begin
		tqsr_pkg::rsp_t exp_rsp;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no request outstanding");
				error_count++;
			end else begin
				exp_rsp = pending_results.pop_front();
				if (rsp.status !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
					error_count++;
				end
				if (rsp.handle_out !== exp_rsp.handle_out) begin
					$error("handle_out: expected %0d, got %0d",
						exp_rsp.handle_out, rsp.handle_out);
					error_count++;
				end
				if (rsp.id_out !== exp_rsp.id_out) begin
					$error("id_out: expected %0d, got %0d", exp_rsp.id_out, rsp.id_out);
					error_count++;
				end
				if (rsp.occupancy !== exp_rsp.occupancy) begin
					$error("occupancy: expected %0d, got %0d",
						exp_rsp.occupancy, rsp.occupancy);
					error_count++;
				end
			end
		end
	end

	// take, lookup and remove on an empty queue all miss
	task automatic test_empty_queue();
		send_cmd(tqsr_pkg::CMD_TAKE, 8'h00, 16'h0000);
		send_cmd(tqsr_pkg::CMD_LOOKUP, 8'hFF, 16'h0000);
		send_cmd(tqsr_pkg::CMD_REMOVE, 8'h00, 16'hFFFF);
	endtask

	// fill all 16 slots with extreme and duplicate values, then one put too many
	task automatic test_fill_to_capacity();
		logic [tqsr_pkg::HANDLE_W-1:0] h;
		logic [tqsr_pkg::ID_W-1:0] id;
		for (int i = 0; i < tqsr_pkg::QUEUE_DEPTH; i++) begin
			case (i)
				0: begin h = 8'hFF; id = 16'hFFFF; end
				1: begin h = 8'h00; id = 16'h0000; end
				2: begin h = 8'h5A; id = 16'h1234; end
				3: begin h = 8'h5A; id = 16'hABCD; end // same handle as slot 2
				4: begin h = 8'h77; id = 16'h1234; end // same id as slot 2
				default: begin
					h = 8'(8'h10 + i);
					id = 16'(16'h8000 + i);
				end
			endcase
			send_cmd(tqsr_pkg::CMD_PUT, h, id);
		end
		// full: refused, queue untouched
		send_cmd(tqsr_pkg::CMD_PUT, 8'h33, 16'h4444);
	endtask

	// duplicates resolve to the oldest entry, misses leave the queue alone
	task automatic test_duplicates_and_gaps();
		send_cmd(tqsr_pkg::CMD_LOOKUP, 8'h00, 16'h1234);  // oldest id match, handle 5a
		send_cmd(tqsr_pkg::CMD_REMOVE, 8'h5A, 16'h0000);  // removes from the middle
		send_cmd(tqsr_pkg::CMD_LOOKUP, 8'hFF, 16'h1234);  // now the later duplicate
		send_cmd(tqsr_pkg::CMD_REMOVE, 8'hEE, 16'hFFFF);  // no such handle
		send_cmd(tqsr_pkg::CMD_LOOKUP, 8'hEE, 16'hEEEE);  // no such id
		send_cmd(tqsr_pkg::CMD_TAKE, 8'hAA, 16'h5555);    // head pops
	endtask

	// handle for a request: often one already queued, else clustered or wide
	function automatic logic [tqsr_pkg::HANDLE_W-1:0] pick_handle();
		if (model_handles.size() > 0 && $urandom_range(3) != 0)
			return model_handles[$urandom_range(model_handles.size() - 1)];
		if ($urandom_range(1) == 0)
			return tqsr_pkg::HANDLE_W'($urandom_range(7));
		return tqsr_pkg::HANDLE_W'($urandom);
	endfunction

	function automatic logic [tqsr_pkg::ID_W-1:0] pick_id();
		if (model_ids.size() > 0 && $urandom_range(3) != 0)
			return model_ids[$urandom_range(model_ids.size() - 1)];
		if ($urandom_range(1) == 0)
			return tqsr_pkg::ID_W'($urandom_range(7));
		return tqsr_pkg::ID_W'($urandom);
	endfunction

	// random commands; put_pct steers the fill level up or down
	task automatic test_random_traffic(input int n_items, input int put_pct);
		int r;
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(99);
			if (r < put_pct) begin
				send_cmd(tqsr_pkg::CMD_PUT, pick_handle(), pick_id());
			end else begin
				// ignored fields get random values so all their bits toggle
				case ($urandom_range(2))
					0: send_cmd(tqsr_pkg::CMD_LOOKUP, tqsr_pkg::HANDLE_W'($urandom),
						pick_id());
					1: send_cmd(tqsr_pkg::CMD_REMOVE, pick_handle(),
						tqsr_pkg::ID_W'($urandom));
					default: send_cmd(tqsr_pkg::CMD_TAKE, tqsr_pkg::HANDLE_W'($urandom),
						tqsr_pkg::ID_W'($urandom));
				endcase
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_fill_to_capacity();
		test_duplicates_and_gaps();
		// sender holds off until the queue of owed results is empty
		wait_for_results();

		test_random_traffic(400, 50);
		wait_for_results();
		test_random_traffic(300, 75);  // mostly full, many refused puts
		wait_for_results();
		test_random_traffic(300, 20);  // mostly empty, many misses
		test_random_traffic(80, 50);

		wait_for_results();
		// idle on so that stray result beats are caught
		repeat (12) @(posedge clk);

		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
